>>> src/bounded_byte_stream_fifo_assert.svh
// Assertion macros for the bounded byte stream FIFO
`ifndef BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH
`define BOUNDED_BYTE_STREAM_FIFO_ASSERT_SVH

// same-cycle implication, checked on clk, quiet in reset
`define BBSF_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bbsf assertion failed");

// next-cycle implication, checked on clk, quiet in reset
`define BBSF_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bbsf assertion failed");

`endif

>>> src/bbsf_pkg.sv
// Shared types and constants for the bounded byte stream FIFO
package bbsf_pkg;

  localparam int MAX_OUT = 64;
  localparam int MAX_AW  = 12;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_PEEK   = 3'd1,
    CMD_POP    = 3'd2,
    CMD_READ   = 3'd3,
    CMD_END    = 3'd4,
    CMD_STATUS = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [6:0] length;
  } request_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        last;
    logic        accepted;
    logic [6:0]  stored_count;
    logic        stream_eof;
    logic        ended;
    logic        error_flag;
    logic [31:0] total_written;
    logic [31:0] total_read;
  } result_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  stored_count;
    logic        stream_eof;
    logic        ended;
    logic        error_flag;
    logic [31:0] total_written;
    logic [31:0] total_read;
  } status_t;

  typedef struct packed {
    logic              burst;
    logic [MAX_AW-1:0] start;
    logic [6:0]        count;
    status_t           st;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [MAX_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

endpackage

>>> src/bbsf_front.sv
// Front end: takes commands, keeps the stream bookkeeping, issues jobs
module bbsf_front import bbsf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  request_t   request,
  output logic       full,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  input  logic       q_full,
  input  logic       burst_busy,
  output logic       job_push,
  output job_t       job,
  output wr_t        wr,
  output logic       error_state
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = (AW + 2 > 8) ? AW + 2 : 8;

  logic [AW-1:0] head, head_next;
  logic [6:0]    fill, fill_next;
  logic          done, done_next;
  logic          err, err_next;
  logic [31:0]   wtot, wtot_next;
  logic [31:0]   rtot, rtot_next;
  logic [6:0]    capacity;

  logic          accept;
  logic          cap_ok;
  logic          over;
  logic [6:0]    m_len;
  logic [6:0]    n_len;
  logic [6:0]    drop;
  logic          inc;
  logic          burst;
  logic [SW-1:0] wsum, wwrap;
  logic [SW-1:0] hsum, hwrap;
  logic [32:0]   wadd, radd;

  assign cfg_ready = 1'b1;
  assign full      = q_full | burst_busy;
  assign accept    = push & ~full;

  assign cap_ok = (SW'(fill) < SW'(capacity)) && (SW'(fill) < SW'(DEPTH));
  assign over   = request.length > fill;
  assign m_len  = over ? fill : request.length;
  assign n_len  = (m_len > 7'(MAX_OUT)) ? 7'(MAX_OUT) : m_len;

  assign wsum  = SW'(head) + SW'(fill);
  assign wwrap = (wsum >= SW'(DEPTH)) ? wsum - SW'(DEPTH) : wsum;

  always_comb begin
    inc      = 1'b0;
    drop     = '0;
    burst    = 1'b0;
    err_next = err;
    done_next = done;
    case (request.command)
      CMD_WRITE: begin
        inc = ~err & cap_ok;
      end
      CMD_PEEK: begin
        burst = ~err && (n_len != '0);
      end
      CMD_READ: begin
        if (!err) begin
          burst = (n_len != '0);
          drop  = n_len;
          if (over) err_next = 1'b1;
        end
      end
      CMD_POP: begin
        if (!err) begin
          drop = m_len;
          if (over) err_next = 1'b1;
        end
      end
      CMD_END: begin
        done_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign hsum      = SW'(head) + SW'(drop);
  assign hwrap     = (hsum >= SW'(DEPTH)) ? hsum - SW'(DEPTH) : hsum;
  assign head_next = hwrap[AW-1:0];
  assign fill_next = fill + 7'(inc) - drop;

  // saturating totals
  assign wadd      = {1'b0, wtot} + 33'(inc);
  assign radd      = {1'b0, rtot} + 33'(drop);
  assign wtot_next = wadd[32] ? 32'hFFFF_FFFF : wadd[31:0];
  assign rtot_next = radd[32] ? 32'hFFFF_FFFF : radd[31:0];

  assign job_push             = accept;
  assign job.burst            = burst;
  assign job.start            = MAX_AW'(head);
  assign job.count            = n_len;
  assign job.st.accepted      = inc;
  assign job.st.stored_count  = fill_next;
  assign job.st.stream_eof    = done_next && (fill_next == '0);
  assign job.st.ended         = done_next;
  assign job.st.error_flag    = err_next;
  assign job.st.total_written = wtot_next;
  assign job.st.total_read    = rtot_next;

  assign wr.en   = accept & inc;
  assign wr.addr = MAX_AW'(wwrap[AW-1:0]);
  assign wr.data = request.data_byte;

  assign error_state = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      fill     <= '0;
      done     <= 1'b0;
      err      <= 1'b0;
      wtot     <= '0;
      rtot     <= '0;
      capacity <= 7'd64;
    end else begin
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
      if (accept) begin
        head <= head_next;
        fill <= fill_next;
        done <= done_next;
        err  <= err_next;
        wtot <= wtot_next;
        rtot <= rtot_next;
      end
    end
  end

endmodule

>>> src/bbsf_jobq.sv
// Two-entry job queue between front and back
module bbsf_jobq import bbsf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t item,
  output logic full,
  input  logic pop,
  output job_t head_item,
  output logic empty,
  output logic burst_queued
);

  job_t       ent [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full      = (cnt == 2'd2);
  assign empty     = (cnt == 2'd0);
  assign head_item = ent[rp];
  assign burst_queued = ((cnt != 2'd0) && ent[rp].burst) ||
                        ((cnt == 2'd2) && ent[~rp].burst);

  always_ff @(posedge clk) begin
    if (push && !full) ent[wp] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

>>> src/bbsf_back.sv
// Back end: byte store, job sequencer and result buffer
module bbsf_back import bbsf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  wr_t     wr,
  input  job_t    job,
  input  logic    job_empty,
  output logic    job_pop,
  output logic    burst_active,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  localparam int AW   = $clog2(DEPTH);
  localparam int OB_N = 4;

  typedef struct packed {
    logic    burst;
    logic    last;
    status_t st;
  } s1_t;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;

  job_t          cur;
  logic          act;
  logic [6:0]    idx;
  logic [AW-1:0] raddr;

  logic          s1v;
  s1_t           s1;

  result_t       obuf [OB_N];
  result_t       ob_in;
  logic [1:0]    owp, orp;
  logic [2:0]    ocnt;

  logic credit, issue, is_last, fin, take, opop;

  assign credit  = ({1'b0, ocnt} + 4'(s1v)) < 4'(OB_N);
  assign issue   = act & credit;
  assign is_last = ~cur.burst || (idx == cur.count - 7'd1);
  assign fin     = issue & is_last;
  assign take    = ~job_empty & (~act | fin);
  assign job_pop = take;
  assign burst_active = act & cur.burst;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
    if (issue && cur.burst) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      s1v <= 1'b0;
    end else begin
      if (take) act <= 1'b1;
      else if (fin) act <= 1'b0;
      s1v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur   <= job;
      idx   <= '0;
      raddr <= job.start[AW-1:0];
    end else if (issue) begin
      idx   <= idx + 7'd1;
      raddr <= (raddr == AW'(DEPTH - 1)) ? '0 : raddr + AW'(1);
    end
    if (issue) begin
      s1.burst <= cur.burst;
      s1.last  <= is_last;
      s1.st    <= cur.st;
    end
  end

  assign ob_in.out_byte      = s1.burst ? rdata : 8'd0;
  assign ob_in.has_byte      = s1.burst;
  assign ob_in.last          = s1.last;
  assign ob_in.accepted      = s1.st.accepted;
  assign ob_in.stored_count  = s1.st.stored_count;
  assign ob_in.stream_eof    = s1.st.stream_eof;
  assign ob_in.ended         = s1.st.ended;
  assign ob_in.error_flag    = s1.st.error_flag;
  assign ob_in.total_written = s1.st.total_written;
  assign ob_in.total_read    = s1.st.total_read;

  // credit check keeps the buffer from overflowing
  assign empty  = (ocnt == 3'd0);
  assign opop   = pop & ~empty;
  assign result = obuf[orp];

  always_ff @(posedge clk) begin
    if (s1v) obuf[owp] <= ob_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (s1v) owp <= owp + 2'd1;
      if (opop) orp <= orp + 2'd1;
      ocnt <= ocnt + 3'(s1v) - 3'(opop);
    end
  end

endmodule

>>> src/bounded_byte_stream_fifo.sv
// Top level of the bounded byte stream FIFO
//
// Usage:
//  - Command beats enter on push/request and are taken while full is low.
//    Commands: write byte, peek, pop, read, end input, status.
//  - Result beats leave on result while empty is low; pop takes one beat.
//    Peek and read give one beat per delivered byte, last on the final one;
//    every other command gives a single beat with has_byte low.
//  - Capacity is written on cfg_valid/cfg_data (cfg_ready is always high);
//    the user must do so only while the block is idle; no check enforces it.
//  - A command's first result goes through the job queue, the sequencer's
//    job register, stage s1 and the result buffer. While that buffer has
//    room, a peek or read gives one byte per cycle from the single read port.
//  - Throughput: one command per cycle while the job queue has room and no
//    byte burst is pending; while a burst is queued or being read out, full
//    stays high so that no write can overwrite bytes still to be delivered.
//  - A stalled receiver fills the four-beat result buffer; the sequencer
//    then waits, the two-entry job queue fills and full rises.
//  - Reset clears all bookkeeping and queues; the byte store itself is not
//    cleared and needs no clearing pass.
module bounded_byte_stream_fifo import bbsf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  request_t   request,
  output logic       full,
  output result_t    result,
  output logic       empty,
  input  logic       pop,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  `include "bounded_byte_stream_fifo_assert.svh"

  job_t job_in, job_out;
  wr_t  wr;
  logic job_push, q_full, q_empty, job_pop;
  logic burst_queued, burst_active, burst_busy;
  logic error_state;

  assign burst_busy = burst_queued | burst_active;

  bbsf_front #(.DEPTH(DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .request     (request),
    .full        (full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .burst_busy  (burst_busy),
    .job_push    (job_push),
    .job         (job_in),
    .wr          (wr),
    .error_state (error_state)
  );

  bbsf_jobq u_jobq (
    .clk          (clk),
    .rst          (rst),
    .push         (job_push),
    .item         (job_in),
    .full         (q_full),
    .pop          (job_pop),
    .head_item    (job_out),
    .empty        (q_empty),
    .burst_queued (burst_queued)
  );

  bbsf_back #(.DEPTH(DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .job          (job_out),
    .job_empty    (q_empty),
    .job_pop      (job_pop),
    .burst_active (burst_active),
    .result       (result),
    .empty        (empty),
    .pop          (pop)
  );

  // store writes never overlap a pending byte burst
  `BBSF_ASSERT_IMP(a_no_write_in_burst, wr.en, !burst_busy)
  // a byte beat never reports a stored write
  `BBSF_ASSERT_IMP(a_byte_not_accepted, !empty && result.has_byte, !result.accepted)
  // error is sticky
  `BBSF_ASSERT_NXT(a_error_sticky, error_state, error_state)

endmodule
